/* hdl/clip_sample_player_with_fades_core_assert.svh */
// Assertion macros shared by the clip player RTL.
`ifndef CLIP_SAMPLE_PLAYER_WITH_FADES_CORE_ASSERT_SVH
`define CLIP_SAMPLE_PLAYER_WITH_FADES_CORE_ASSERT_SVH
// Same-cycle implication.
`define CSPF_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CSPF_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/cspf_pkg.sv */
// ----------------------------------------------------------------------------
// cspf_pkg
// Shared types, widths and codes of the clip sample player.
// ----------------------------------------------------------------------------
package cspf_pkg;

  localparam int CLIP_DEPTH_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int KIND_W     = 2;
  localparam int ADDR_IN_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int POS_W        = 33;   // Q17.16 read position
  localparam int FRAC_W       = 16;
  localparam int IDX_W        = POS_W - FRAC_W;
  localparam int TRIM_START_W = 16;
  localparam int LEN_W        = 17;   // trim end and fade lengths
  localparam int STEP_W       = 19;
  localparam int START_W      = 32;
  localparam int GAIN_W       = 16;
  localparam int GAIN_SHIFT   = 14;
  localparam int ENV_W        = 17;   // envelope, 1.0 = 65536
  localparam int QUO_W        = 16;
  localparam int MUL_B_W      = 17;

  localparam logic [STEP_W-1:0] RATE_STEP_RST = 19'h10000;
  localparam logic [GAIN_W-1:0] CLIP_GAIN_RST = 16'h4000;
  localparam logic [ENV_W-1:0]  ENV_ONE       = 17'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM_START   = 3'd0,
    REG_TRIM_END     = 3'd1,
    REG_FADE_IN_LEN  = 3'd2,
    REG_FADE_OUT_LEN = 3'd3,
    REG_RATE_STEP    = 3'd4,
    REG_START_POS    = 3'd5,
    REG_CLIP_GAIN    = 3'd6,
    REG_MONO_CLIP    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

/* hdl/cspf_req_if.sv */
// ----------------------------------------------------------------------------
// cspf_req_if
// Input item channel: load, restart or tick.
// ----------------------------------------------------------------------------
interface cspf_req_if #(
  parameter int SAMPLE_BITS = cspf_pkg::SAMPLE_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [cspf_pkg::KIND_W-1:0]        kind;
  logic [cspf_pkg::ADDR_IN_W-1:0]     sample_addr;
  logic signed [SAMPLE_BITS-1:0]      left_in;
  logic signed [SAMPLE_BITS-1:0]      right_in;

  modport source (output valid, kind, sample_addr, left_in, right_in, input ready);
  modport sink   (input valid, kind, sample_addr, left_in, right_in, output ready);
endinterface

/* hdl/cspf_rsp_if.sv */
// ----------------------------------------------------------------------------
// cspf_rsp_if
// Result item channel: mixed bus sample pair and end flag.
// ----------------------------------------------------------------------------
interface cspf_rsp_if #(
  parameter int SAMPLE_BITS = cspf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          clip_ended;

  modport source (output valid, left_out, right_out, clip_ended, input ready);
  modport sink   (input valid, left_out, right_out, clip_ended, output ready);
endinterface

/* hdl/clip_sample_player_with_fades_core.sv */
// Load and restart items complete as they are accepted; a tick outside the window
// passes straight to the result stage. A tick inside the trim window runs the
// bit-serial multipliers, three products in a row, four with an active fade-out,
// and they set how long it takes.
// One item at a time; the result register lets the next item enter while it waits.
// Reset (rst, synchronous, active high) stops playback, zeroes the position and
// loads register defaults; the clip stores are undefined until loaded.
// ----------------------------------------------------------------------------
// clip_sample_player_with_fades_core
// Plays a stored stereo clip into a stereo bus with trim window, linear fades,
// linear-interpolation resampling and gain, saturating the mix.
// ----------------------------------------------------------------------------
module clip_sample_player_with_fades_core #(
  parameter int CLIP_DEPTH  = cspf_pkg::CLIP_DEPTH_DEF,
  parameter int SAMPLE_BITS = cspf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cspf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspf_pkg::CFG_DATA_W-1:0] cfg_data,
  cspf_req_if.sink                        req,
  cspf_rsp_if.source                      rsp
);

  `include "clip_sample_player_with_fades_core_assert.svh"

  localparam int SB     = SAMPLE_BITS;
  localparam int ADDR_W = $clog2(CLIP_DEPTH);
  localparam int DIFF_W = SB + 1;
  localparam int I_W    = SB + 17;  // interpolated sample, Q.16
  localparam int T_W    = SB + 19;  // after gain
  localparam int MA_W   = T_W;
  localparam int MB_W   = cspf_pkg::MUL_B_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int C_W    = SB + 4;
  localparam int SUM_W  = SB + 5;
  localparam int POS_W  = cspf_pkg::POS_W;
  localparam int FRAC_W = cspf_pkg::FRAC_W;
  localparam int IDX_W  = cspf_pkg::IDX_W;
  localparam int LEN_W  = cspf_pkg::LEN_W;
  localparam int ENV_W  = cspf_pkg::ENV_W;
  localparam logic [31:0] DEPTH32 = 32'(CLIP_DEPTH);
  localparam logic signed [P_W-1:0] HALF = {{(P_W-32){1'b0}}, 32'h8000_0000};

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_P1, S_P2, S_P3, S_P4, S_OUT
  } state_t;

  // Configuration registers
  logic [cspf_pkg::TRIM_START_W-1:0] trim_start;
  logic [LEN_W-1:0]                  trim_end;
  logic [LEN_W-1:0]                  fade_in_len;
  logic [LEN_W-1:0]                  fade_out_len;
  logic [cspf_pkg::STEP_W-1:0]       rate_step;
  logic [cspf_pkg::START_W-1:0]      start_pos;
  logic [cspf_pkg::GAIN_W-1:0]       clip_gain;
  logic                              mono_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_start   <= '0;
      trim_end     <= '0;
      fade_in_len  <= '0;
      fade_out_len <= '0;
      rate_step    <= cspf_pkg::RATE_STEP_RST;
      start_pos    <= '0;
      clip_gain    <= cspf_pkg::CLIP_GAIN_RST;
      mono_clip    <= 1'b0;
    end else if (cfg_we) begin
      case (cspf_pkg::reg_idx_t'(cfg_index))
        cspf_pkg::REG_TRIM_START:   trim_start   <= cfg_data[cspf_pkg::TRIM_START_W-1:0];
        cspf_pkg::REG_TRIM_END:     trim_end     <= cfg_data[LEN_W-1:0];
        cspf_pkg::REG_FADE_IN_LEN:  fade_in_len  <= cfg_data[LEN_W-1:0];
        cspf_pkg::REG_FADE_OUT_LEN: fade_out_len <= cfg_data[LEN_W-1:0];
        cspf_pkg::REG_RATE_STEP:    rate_step    <= cfg_data[cspf_pkg::STEP_W-1:0];
        cspf_pkg::REG_START_POS:    start_pos    <= cfg_data[cspf_pkg::START_W-1:0];
        cspf_pkg::REG_CLIP_GAIN:    clip_gain    <= cfg_data[cspf_pkg::GAIN_W-1:0];
        cspf_pkg::REG_MONO_CLIP:    mono_clip    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Playback state and per-tick working registers
  state_t              state;
  logic [POS_W-1:0]    pos;
  logic                playing;
  logic [IDX_W-1:0]    idx_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [LEN_W-1:0]    rel_r;
  logic [LEN_W-1:0]    from_end_r;
  logic                fi_act;
  logic                fo_act;
  logic                v1;
  logic                v2;
  logic signed [SB-1:0] bus_l, bus_r;
  logic signed [SB-1:0] s1_l, s1_r;
  logic [ENV_W-1:0]    env_r;
  logic signed [T_W-1:0] t_l, t_r;
  logic signed [SB-1:0] res_l, res_r;
  logic                res_end;

  // Item decode
  cspf_pkg::kind_t  kind_in;
  logic             acc;
  logic [IDX_W-1:0] idx;
  logic [FRAC_W-1:0] frac;
  logic             past_end;
  logic             before_win;
  logic [LEN_W-1:0] rel_now;
  logic [LEN_W-1:0] from_end_now;

  assign req.ready    = (state == S_IDLE);
  assign acc          = req.valid && req.ready;
  assign kind_in      = cspf_pkg::kind_t'(req.kind);
  assign idx          = pos[POS_W-1:FRAC_W];
  assign frac         = pos[FRAC_W-1:0];
  assign past_end     = idx >= trim_end;
  assign before_win   = idx < IDX_W'(trim_start);
  assign rel_now      = idx - IDX_W'(trim_start);
  assign from_end_now = trim_end - idx;

  // Clip stores: write on load, read idx then idx+1 on a tick
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_idx32;
  logic [31:0]       wr_idx32;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_ok;
  logic              mem_we;
  logic [SB-1:0]     rd_l, rd_r;

  assign rd_idx   = (state == S_IDLE) ? idx : (idx_r + IDX_W'(1));
  assign rd_idx32 = 32'(rd_idx);
  assign rd_addr  = rd_idx32[ADDR_W-1:0];
  assign rd_ok    = rd_idx32 < DEPTH32;
  assign wr_idx32 = 32'(req.sample_addr);
  assign wr_addr  = wr_idx32[ADDR_W-1:0];
  assign mem_we   = acc && (kind_in == cspf_pkg::KIND_LOAD) && (wr_idx32 < DEPTH32);

  cspf_ram #(.DEPTH(CLIP_DEPTH), .ADDR_W(ADDR_W), .DATA_W(SB)) u_ram_l (
    .clk(clk), .we(mem_we), .waddr(wr_addr), .wdata(req.left_in),
    .raddr(rd_addr), .rdata(rd_l)
  );

  cspf_ram #(.DEPTH(CLIP_DEPTH), .ADDR_W(ADDR_W), .DATA_W(SB)) u_ram_r (
    .clk(clk), .we(mem_we), .waddr(wr_addr), .wdata(req.right_in),
    .raddr(rd_addr), .rdata(rd_r)
  );

  // Mono clip: left store feeds the right lane too
  logic signed [SB-1:0] cur_l, cur_r, s2_l, s2_r;
  logic signed [DIFF_W-1:0] diff_l, diff_r;

  assign cur_l  = signed'(rd_l);
  assign cur_r  = mono_clip ? signed'(rd_l) : signed'(rd_r);
  assign s2_l   = v2 ? cur_l : '0;
  assign s2_r   = v2 ? cur_r : '0;
  assign diff_l = DIFF_W'(s2_l) - DIFF_W'(s1_l);
  assign diff_r = DIFF_W'(s2_r) - DIFF_W'(s1_r);

  // Shared serial units: one multiplier per lane, one divider for the fades
  logic                    ml_start, mr_start, dv_start;
  logic signed [MA_W-1:0]  a_l, a_r;
  logic [MB_W-1:0]         b_l, b_r;
  logic signed [P_W-1:0]   prod_l, prod_r;
  logic [LEN_W-1:0]        dv_num, dv_den;
  logic [cspf_pkg::QUO_W-1:0] dv_q;
  cspf_pkg::unit_sts_t     ml_sts, mr_sts, dv_sts;

  cspf_smul #(.A_W(MA_W), .B_W(MB_W)) u_mul_l (
    .clk(clk), .rst(rst), .start(ml_start), .a(a_l), .b(b_l), .prod(prod_l), .sts(ml_sts)
  );

  cspf_smul #(.A_W(MA_W), .B_W(MB_W)) u_mul_r (
    .clk(clk), .rst(rst), .start(mr_start), .a(a_r), .b(b_r), .prod(prod_r), .sts(mr_sts)
  );

  cspf_sdiv #(.N_W(LEN_W), .Q_W(cspf_pkg::QUO_W)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .quo(dv_q), .sts(dv_sts)
  );

  // Products read back between phases
  logic signed [I_W-1:0] i_l, i_r;
  logic signed [T_W-1:0] tn_l, tn_r;
  logic [ENV_W-1:0]      env_new;
  logic signed [P_W-1:0] rnd_l, rnd_r;
  logic signed [C_W-1:0] c_l, c_r;
  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic signed [SB-1:0]  sat_l, sat_r;

  // I = s1 * 65536 + frac * (s2 - s1)
  assign i_l     = (I_W'(s1_l) <<< FRAC_W) + I_W'(prod_l);
  assign i_r     = (I_W'(s1_r) <<< FRAC_W) + I_W'(prod_r);
  // T = floor(I * gain / 16384)
  assign tn_l    = T_W'(prod_l >>> cspf_pkg::GAIN_SHIFT);
  assign tn_r    = T_W'(prod_r >>> cspf_pkg::GAIN_SHIFT);
  // fade-in envelope times fade-out factor, back to Q.16
  assign env_new = prod_l[FRAC_W+ENV_W-1:FRAC_W];
  // C = floor((T * E + 2^31) / 2^32)
  assign rnd_l   = prod_l + HALF;
  assign rnd_r   = prod_r + HALF;
  assign c_l     = C_W'(rnd_l >>> 32);
  assign c_r     = C_W'(rnd_r >>> 32);
  assign sum_l   = SUM_W'(bus_l) + SUM_W'(c_l);
  assign sum_r   = SUM_W'(bus_r) + SUM_W'(c_r);
  // saturate when the bits above the sample's sign disagree
  assign sat_l   = ((&sum_l[SUM_W-1:SB-1]) || !(|sum_l[SUM_W-1:SB-1])) ? sum_l[SB-1:0]
                   : {sum_l[SUM_W-1], {(SB-1){~sum_l[SUM_W-1]}}};
  assign sat_r   = ((&sum_r[SUM_W-1:SB-1]) || !(|sum_r[SUM_W-1:SB-1])) ? sum_r[SB-1:0]
                   : {sum_r[SUM_W-1], {(SB-1){~sum_r[SUM_W-1]}}};

  // Launch the serial units at each phase change
  always_comb begin
    ml_start = 1'b0;
    mr_start = 1'b0;
    dv_start = 1'b0;
    a_l      = '0;
    a_r      = '0;
    b_l      = '0;
    b_r      = '0;
    dv_num   = rel_r;
    dv_den   = fade_in_len;
    case (state)
      S_RD2: begin
        // interpolation step and fade-in division
        ml_start = 1'b1;
        mr_start = 1'b1;
        a_l      = MA_W'(diff_l);
        a_r      = MA_W'(diff_r);
        b_l      = MB_W'(frac_r);
        b_r      = MB_W'(frac_r);
        dv_start = fi_act;
      end
      S_P1: begin
        if (ml_sts.done) begin
          // gain, and the fade-out division alongside
          ml_start = 1'b1;
          mr_start = 1'b1;
          a_l      = MA_W'(i_l);
          a_r      = MA_W'(i_r);
          b_l      = MB_W'(clip_gain);
          b_r      = MB_W'(clip_gain);
          dv_start = fo_act;
          dv_num   = from_end_r;
          dv_den   = fade_out_len;
        end
      end
      S_P2: begin
        if (ml_sts.done) begin
          if (fo_act) begin
            // combine the two fade factors on the left lane
            ml_start = 1'b1;
            a_l      = MA_W'(env_r);
            b_l      = MB_W'(dv_q);
          end else begin
            ml_start = 1'b1;
            mr_start = 1'b1;
            a_l      = MA_W'(tn_l);
            a_r      = MA_W'(tn_r);
            b_l      = MB_W'(env_r);
            b_r      = MB_W'(env_r);
          end
        end
      end
      S_P3: begin
        if (ml_sts.done) begin
          ml_start = 1'b1;
          mr_start = 1'b1;
          a_l      = t_l;
          a_r      = t_r;
          b_l      = MB_W'(env_new);
          b_r      = MB_W'(env_new);
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      playing   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it this cycle
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          v1 <= rd_ok;
          if (acc) begin
            case (kind_in)
              cspf_pkg::KIND_LOAD: ;
              cspf_pkg::KIND_RESTART: begin
                pos     <= POS_W'(start_pos);
                playing <= 1'b1;
              end
              cspf_pkg::KIND_TICK: begin
                bus_l   <= req.left_in;
                bus_r   <= req.right_in;
                res_l   <= req.left_in;
                res_r   <= req.right_in;
                res_end <= playing && past_end;
                if (!playing) begin
                  state <= S_OUT;
                end else if (past_end) begin
                  // stop and flag; the position holds
                  playing <= 1'b0;
                  state   <= S_OUT;
                end else begin
                  pos <= pos + POS_W'(rate_step);
                  if (before_win) begin
                    state <= S_OUT;
                  end else begin
                    idx_r      <= idx;
                    frac_r     <= frac;
                    rel_r      <= rel_now;
                    from_end_r <= from_end_now;
                    fi_act     <= (fade_in_len != '0) && (rel_now < fade_in_len);
                    fo_act     <= (fade_out_len != '0) && (from_end_now < fade_out_len);
                    state      <= S_RD1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RD1: begin
          // first sample arrives; address the second
          v2    <= rd_ok;
          s1_l  <= v1 ? cur_l : '0;
          s1_r  <= v1 ? cur_r : '0;
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_P1;
        end
        S_P1: begin
          if (ml_sts.done) begin
            env_r <= fi_act ? ENV_W'(dv_q) : cspf_pkg::ENV_ONE;
            state <= S_P2;
          end
        end
        S_P2: begin
          if (ml_sts.done) begin
            t_l   <= tn_l;
            t_r   <= tn_r;
            state <= fo_act ? S_P3 : S_P4;
          end
        end
        S_P3: begin
          if (ml_sts.done) begin
            env_r <= env_new;
            state <= S_P4;
          end
        end
        S_P4: begin
          if (ml_sts.done) begin
            res_l <= sat_l;
            res_r <= sat_r;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.left_out   <= res_l;
            rsp.right_out  <= res_r;
            rsp.clip_ended <= res_end;
            rsp.valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `CSPF_ASSERT_IMPLY(a_busy_playing, clk, rst, (state != S_IDLE && state != S_OUT), playing, "computing a tick while stopped")
  `CSPF_ASSERT_IMPLY(a_lanes_lockstep, clk, rst, (state == S_P1 || state == S_P4), (ml_sts.done == mr_sts.done), "multiplier lanes out of step")
  `CSPF_ASSERT_IMPLY(a_div_first, clk, rst, (state == S_P1 && ml_sts.done), !dv_sts.busy, "fade division still running")
  `CSPF_ASSERT_NEXT(a_tick_result, clk, rst, (acc && kind_in == cspf_pkg::KIND_TICK), (state != S_IDLE), "tick item dropped")

endmodule

/* hdl/cspf_ram.sv */
// ----------------------------------------------------------------------------
// cspf_ram
// Clip sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cspf_ram #(
  parameter int DEPTH  = cspf_pkg::CLIP_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = cspf_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cspf_smul.sv */
// ----------------------------------------------------------------------------
// cspf_smul
// Bit-serial multiplier: signed A times unsigned B, one B bit per cycle.
// ----------------------------------------------------------------------------
module cspf_smul #(
  parameter int A_W = cspf_pkg::SAMPLE_BITS_DEF + 19,
  parameter int B_W = cspf_pkg::MUL_B_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [A_W-1:0]     a,
  input  logic [B_W-1:0]            b,
  output logic signed [A_W+B_W-1:0] prod,
  output cspf_pkg::unit_sts_t       sts
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic signed [P_W-1:0] mcand;
  logic [B_W-1:0]        mplier;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod   <= '0;
        mcand  <= P_W'(a);
        mplier <= b;
        cnt    <= CNT_W'(B_W);
        busy   <= 1'b1;
      end else if (busy) begin
        // add the shifted multiplicand for each set multiplier bit
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

/* hdl/cspf_sdiv.sv */
// ----------------------------------------------------------------------------
// cspf_sdiv
// Bit-serial restoring divider: (num << Q_W) / den for num below den.
// ----------------------------------------------------------------------------
module cspf_sdiv #(
  parameter int N_W = cspf_pkg::LEN_W,
  parameter int Q_W = cspf_pkg::QUO_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [N_W-1:0]      num,
  input  logic [N_W-1:0]      den,
  output logic [Q_W-1:0]      quo,
  output cspf_pkg::unit_sts_t sts
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [N_W:0]     rem;
  logic [N_W:0]     rem2;
  logic [N_W-1:0]   den_r;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign rem2 = {rem[N_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= {1'b0, num};
        den_r <= den;
        quo   <= '0;
        cnt   <= CNT_W'(Q_W);
        busy  <= 1'b1;
      end else if (busy) begin
        // one quotient bit per cycle
        rem <= ge ? (rem2 - {1'b0, den_r}) : rem2;
        quo <= {quo[Q_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

/* dv/tb_clip_sample_player_with_fades_core.sv */
// ----------------------------------------------------------------------------
// tb_clip_sample_player_with_fades_core
// Self-checking bench for the clip player: loads clip windows, restarts
// playback and ticks bus samples through it under random gaps and stalls,
// predicting every mixed sample pair and end flag in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_clip_sample_player_with_fades_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cspf_pkg::*;

  // Unused item kind: the block must drop it.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Mixed sample pair and end flag predicted for one tick.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               ended;
  } mix_result_t;

  // Holds its own copy of clip, position and registers; one expected mix per tick.
  class mix_scoreboard;
    logic signed [15:0] left_clip[int];
    logic signed [15:0] right_clip[int];
    logic [32:0] position;
    bit          playing;
    logic [15:0] trim_start;
    logic [16:0] trim_end, fade_in_len, fade_out_len;
    logic [18:0] rate_step;
    logic [31:0] start_pos;
    logic [15:0] clip_gain;
    bit          mono_clip;
    mix_result_t expected_mix[$];
    int errors, ticks_checked, ends_checked;

    function new();
      position = '0; playing = 0;
      trim_start = '0; trim_end = '0; fade_in_len = '0; fade_out_len = '0;
      rate_step = RATE_STEP_RST; start_pos = '0; clip_gain = CLIP_GAIN_RST;
      mono_clip = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_TRIM_START:   trim_start = v[15:0];
        REG_TRIM_END:     trim_end = v[16:0];
        REG_FADE_IN_LEN:  fade_in_len = v[16:0];
        REG_FADE_OUT_LEN: fade_out_len = v[16:0];
        REG_RATE_STEP:    rate_step = v[18:0];
        REG_START_POS:    start_pos = v;
        REG_CLIP_GAIN:    clip_gain = v[15:0];
        REG_MONO_CLIP:    mono_clip = v[0];
        default: ;
      endcase
    endfunction

    function longint clip_sample(bit right_side, longint idx);
      if (idx >= 65536) return 0;
      if (right_side && !mono_clip) return right_clip.exists(idx) ? right_clip[idx] : 0;
      return left_clip.exists(idx) ? left_clip[idx] : 0;
    endfunction

    function longint clip_term(bit right_side, longint idx, longint frac, longint env);
      longint s1, s2, interp, scaled;
      s1 = clip_sample(right_side, idx);
      s2 = clip_sample(right_side, idx + 1);
      interp = s1 * 65536 + frac * (s2 - s1);
      scaled = (interp * longint'(clip_gain)) >>> 14;
      return (scaled * env + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function logic signed [15:0] saturate(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
    endfunction

    function void note_item(logic [1:0] kind, logic [15:0] addr,
                            logic signed [15:0] lin, logic signed [15:0] rin);
      mix_result_t res;
      longint idx, rel, from_end, env, frac;
      if (kind == KIND_LOAD) begin
        left_clip[addr] = lin;
        right_clip[addr] = rin;
      end else if (kind == KIND_RESTART) begin
        position = {1'b0, start_pos};
        playing = 1;
      end else if (kind == KIND_TICK) begin
        res.left = lin; res.right = rin; res.ended = 0;
        if (playing) begin
          idx = position[32:16];
          if (idx >= trim_end) begin
            playing = 0;
            res.ended = 1;
          end else begin
            if (idx >= trim_start) begin
              rel = idx - trim_start;
              from_end = trim_end - idx;
              env = 65536;
              frac = position[15:0];
              if (fade_in_len > 0 && rel < fade_in_len)
                env = (rel << 16) / fade_in_len;
              if (fade_out_len > 0 && from_end < fade_out_len)
                env = (env * ((from_end << 16) / fade_out_len)) >>> 16;
              res.left = saturate(longint'(lin) + clip_term(0, idx, frac, env));
              res.right = saturate(longint'(rin) + clip_term(1, idx, frac, env));
            end
            position = position + rate_step;
          end
        end
        expected_mix.insert(expected_mix.size(), res);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [15:0] lout, logic signed [15:0] rout, logic ended);
      mix_result_t exp_r;
      if (expected_mix.size() == 0) begin
        report($sformatf("unexpected result L=%0d R=%0d end=%0b", lout, rout, ended));
      end else begin
        exp_r = expected_mix.pop_front();
        ticks_checked++;
        if (ended) ends_checked++;
        if (lout !== exp_r.left)
          report($sformatf("left_out %0d, want %0d", lout, exp_r.left));
        if (rout !== exp_r.right)
          report($sformatf("right_out %0d, want %0d", rout, exp_r.right));
        if (ended !== exp_r.ended)
          report($sformatf("clip_ended %0b, want %0b", ended, exp_r.ended));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cspf_req_if req_ch ();
  cspf_rsp_if rsp_ch ();

  clip_sample_player_with_fades_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  mix_scoreboard sb = new();
  bit quiet;          // when set, neither side idles
  int items_sent;
  int phases_run;
  int stall_left;

  // Sample both handshakes at the edge; drivers only change values by NBA.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_item(req_ch.kind, req_ch.sample_addr, req_ch.left_in, req_ch.right_in);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.left_out, rsp_ch.right_out, rsp_ch.clip_ended);
    end
  end

  // Result side: draw a stall per accepted result; hold ready low while it runs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 0;
      stall_left = 0;
    end else begin
      int n;
      n = stall_left;
      if (rsp_ch.valid && rsp_ch.ready) n = quiet ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        rsp_ch.ready <= 0;
        stall_left = n - 1;
      end else begin
        rsp_ch.ready <= 1;
        stall_left = 0;
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted.
  task send_item(logic [1:0] kind, logic [15:0] addr,
                 logic signed [15:0] lin, logic signed [15:0] rin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.kind <= kind;
    req_ch.sample_addr <= addr;
    req_ch.left_in <= lin;
    req_ch.right_in <= rin;
    do @(posedge clk); while (!req_ch.ready);
    if (kind != KIND_SPARE) items_sent++;
  endtask

  task tick(logic signed [15:0] lin, logic signed [15:0] rin);
    send_item(KIND_TICK, 16'($urandom), lin, rin);
  endtask

  // Drain all results, then allow for a load or restart still in flight.
  task drain();
    req_ch.valid <= 0;
    while (sb.expected_mix.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task configure(logic [31:0] ts, logic [31:0] te, logic [31:0] fin, logic [31:0] fout,
                 logic [31:0] step, logic [31:0] sp, logic [31:0] gain, logic [31:0] mono);
    write_reg(REG_TRIM_START, ts);
    write_reg(REG_TRIM_END, te);
    write_reg(REG_FADE_IN_LEN, fin);
    write_reg(REG_FADE_OUT_LEN, fout);
    write_reg(REG_RATE_STEP, step);
    write_reg(REG_START_POS, sp);
    write_reg(REG_CLIP_GAIN, gain);
    write_reg(REG_MONO_CLIP, mono);
    cfg_we <= 0;
  endtask

  function logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load every entry the window can read: trim start through trim end inclusive.
  task load_window(int ts, int te);
    for (int a = ts; a <= te && a < 65536; a++)
      send_item(KIND_LOAD, 16'(a), pick_sample(), pick_sample());
  endtask

  // One random playback phase: idle config, window load, restart, ticks, noise.
  task random_phase();
    int ts, te, len, fin, fout, step, sp, gain, nticks;
    len = $urandom_range(0, 20);
    case ($urandom_range(0, 4))
      0: ts = 0;
      1: ts = 65535 - $urandom_range(0, 3);
      default: ts = $urandom_range(0, 65535);
    endcase
    te = ts + len;
    case ($urandom_range(0, 9))
      0: te = 65536;
      1: te = $urandom_range(0, ts);       // empty window: ends at once
      default: ;
    endcase
    if (te > 65536) te = 65536;
    // Keep the readable span short so loading it stays cheap.
    if (te - ts > 24) te = ts + 24;
    case ($urandom_range(0, 4))
      0: fin = 0;
      1: fin = 65536;
      2: fin = $urandom_range(0, 131071);
      default: fin = $urandom_range(1, len + 2);
    endcase
    case ($urandom_range(0, 4))
      0: fout = 0;
      1: fout = 65536;
      2: fout = $urandom_range(0, 131071);
      default: fout = $urandom_range(1, len + 2);
    endcase
    case ($urandom_range(0, 7))
      0: step = 0;
      1: step = 524287;
      2: step = $urandom_range(0, 524287);
      default: step = $urandom_range(8192, 131072);
    endcase
    case ($urandom_range(0, 7))
      0: sp = $urandom;
      1: sp = 32'hffffffff;
      2: sp = ((ts > 3 ? ts - 3 : 0) << 16) | $urandom_range(0, 65535);
      default: sp = (ts << 16) | $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 4))
      0: gain = 0;
      1: gain = 65535;
      2: gain = 16384;
      default: gain = $urandom_range(0, 65535);
    endcase
    quiet = ($urandom_range(0, 5) == 0);
    drain();
    configure(ts, te, fin, fout, step, sp, gain, $urandom_range(0, 1));
    load_window(ts, te);
    if ($urandom_range(0, 4) == 0) tick(pick_sample(), pick_sample());
    send_item(KIND_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
    nticks = $urandom_range(4, 40);
    for (int k = 0; k < nticks; k++) begin
      case ($urandom_range(0, 19))
        0: send_item(KIND_SPARE, 16'($urandom), 16'($urandom), 16'($urandom));
        1: send_item(KIND_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
        2: send_item(KIND_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        default: tick(pick_sample(), pick_sample());
      endcase
    end
    phases_run++;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    req_ch.valid = 0; req_ch.kind = '0; req_ch.sample_addr = '0;
    req_ch.left_in = '0; req_ch.right_in = '0;
    rsp_ch.ready = 0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset settings: not playing passes through, an empty window ends at once.
    tick(16'sh7fff, -16'sh8000);
    send_item(KIND_SPARE, 16'hffff, -16'sd1, -16'sd1);
    send_item(KIND_RESTART, '0, '0, '0);
    tick(-16'sh8000, 16'sh7fff);
    tick(16'sh1234, -16'sh1234);
    drain();

    // Half-rate play through a short window with both fades and maximum gain.
    configure(100, 104, 3, 2, 32768, 100 << 16, 65535, 0);
    for (int a = 100; a <= 104; a++)
      send_item(KIND_LOAD, 16'(a), (a % 2) ? 16'sh7fff : -16'sh8000,
                (a % 2) ? -16'sh8000 : 16'sh7fff);
    send_item(KIND_RESTART, '0, '0, '0);
    for (int k = 0; k < 12; k++)
      tick((k % 2) ? 16'sh7000 : -16'sh7000, (k % 3) ? 16'sh7fff : -16'sh8000);

    while (items_sent < 1750) random_phase();

    quiet = 0;
    drain();
    $display("covered %0d items in %0d phases: %0d ticks checked, %0d clip ends",
             items_sent, phases_run, sb.ticks_checked, sb.ends_checked);
    if (sb.errors == 0) begin
      $display("tb_clip_sample_player_with_fades_core: done, clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_clip_sample_player_with_fades_core: done, errors");
    end
    $finish;
  end

  // Run ends here if the block hangs.
  initial begin
    #20ms;
    $display("timeout");
    $display("tb_clip_sample_player_with_fades_core: done, errors");
    $finish;
  end

endmodule
